[design/wbrp_pkg.sv]
package wbrp_pkg;

  // Header layout.
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned SEQ_BYTES    = 8;

  // Parse phases; each phase value doubles as the role code of its bytes.
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_TAG     = 3'd1;
  localparam logic [2:0] PH_KLEN    = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_VLEN    = 3'd4;
  localparam logic [2:0] PH_VAL     = 3'd5;
  localparam logic [2:0] PH_DISCARD = 3'd6;

  // Batch status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SMALL  = 3'd1;
  localparam logic [2:0] ST_BADPUT = 3'd2;
  localparam logic [2:0] ST_BADDEL = 3'd3;
  localparam logic [2:0] ST_BADTAG = 3'd4;
  localparam logic [2:0] ST_COUNT  = 3'd5;

  // Configuration register indexes.
  localparam logic [7:0] CFG_PUT_TAG    = 8'd0;
  localparam logic [7:0] CFG_DELETE_TAG = 8'd1;

  // Record kinds.
  localparam logic OP_PUT    = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic [2:0]  byte_role;
    logic        record_op;
    logic        field_end;
    logic        record_end;
    logic [63:0] record_seq;
    logic        done_res;
    logic [2:0]  status;
  } out_beat_t;

  // Classified byte handed from the front to the back through the queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_put;
    logic       is_del;
  } cls_t;

endpackage

[design/write_batch_record_parser_top.sv]
// Channel | Direction | Signals                        | Beat
// --------+-----------+--------------------------------+-----------------------------
// in      | input     | in_valid, in_ready, in_data    | one batch byte, last flag
// out     | output    | out_valid, out_ready, out_data | role, marks, sequence, status
// cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data | one tag register
//
// One byte per cycle sustained while out is ready; a byte enters the queue when accepted,
// and the parse step loads its result into the output register when it leaves the queue.
// While out is stalled the queue takes up to QUEUE_DEPTH more beats before in_ready drops.
// Reset is synchronous: tags return to put 1 and delete 0, the parser to the header.
// The cfg port is always ready; a write takes effect on the next cycle.
module write_batch_record_parser_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wbrp_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wbrp_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  localparam int unsigned CLS_W = $bits(wbrp_pkg::cls_t);

  logic           q_full;
  logic           q_push;
  wbrp_pkg::cls_t q_wr;
  logic           q_valid;
  logic           q_ready;
  wbrp_pkg::cls_t q_rd;

  // Front: tag registers and byte classification.
  wbrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr)
  );

  // Queue between the two halves.
  wbrp_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_push),
    .wr_data  (q_wr),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_rd)
  );

  // Back: batch parser and output register.
  wbrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_rd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Status is only reported on the last byte.
  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.done_res |-> out_data.status == wbrp_pkg::ST_OK)
    else $error("status set on a byte that is not the last");

  // Every record end also closes a field.
  a_record_end_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.record_end |-> out_data.field_end)
    else $error("record end without field end");

  // Header bytes carry no record information.
  a_header_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_role == wbrp_pkg::PH_HEADER |->
      out_data.record_seq == 64'd0 && !out_data.record_op &&
      !out_data.field_end && !out_data.record_end)
    else $error("record marks on a header byte");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

[design/wbrp_front.sv]
module wbrp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  wbrp_pkg::in_beat_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output wbrp_pkg::cls_t    q_data
);

  logic [7:0] put_tag;
  logic [7:0] delete_tag;

  // Tag registers; a write lands in its register at the clock edge, so the port is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      put_tag    <= 8'd1;
      delete_tag <= 8'd0;
    end else if (cfg_valid) begin
      if (cfg_index == wbrp_pkg::CFG_PUT_TAG) begin
        put_tag <= cfg_data;
      end else if (cfg_index == wbrp_pkg::CFG_DELETE_TAG) begin
        delete_tag <= cfg_data;
      end
    end
  end

  // A beat enters whenever the queue has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Tag matches are worked out here; a put match wins over a delete match.
  always_comb begin
    q_data.data_byte = in_data.data_byte;
    q_data.last_byte = in_data.last_byte;
    q_data.is_put    = (in_data.data_byte == put_tag);
    q_data.is_del    = (in_data.data_byte == delete_tag) &&
                       (in_data.data_byte != put_tag);
  end

endmodule

[design/wbrp_fifo.sv]
module wbrp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && !full;
  assign do_rd    = rd_valid && rd_ready;

  // Storage; entries need no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[design/wbrp_back.sv]
module wbrp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  wbrp_pkg::cls_t     q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wbrp_pkg::out_beat_t out_data
);

  // Parser state.
  logic [2:0]  phase,     phase_next;
  logic [3:0]  hdr_idx,   hdr_idx_next;
  logic [63:0] base_seq,  base_seq_next;
  logic [31:0] decl_count, decl_count_next;
  logic [31:0] rec_count, rec_count_next;
  logic [31:0] vacc,      vacc_next;
  logic [2:0]  vbytes,    vbytes_next;
  logic [31:0] remain,    remain_next;
  logic        cur_op,    cur_op_next;
  logic [2:0]  err_code,  err_code_next;
  logic [63:0] cur_seq,   cur_seq_next;

  logic                take;
  logic [7:0]          b;
  logic                is_key;
  logic                fin;
  logic                in_rec;
  logic [38:0]         shifted;
  logic [31:0]         vacc_or;
  wbrp_pkg::out_beat_t beat;

  assign b       = q_data.data_byte;
  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;
  assign is_key  = (phase == wbrp_pkg::PH_KLEN) || (phase == wbrp_pkg::PH_KEY);

  // Varint payload bits placed at their group position.
  assign shifted = 39'(b[6:0]) << (6'(vbytes) * 6'd7);
  assign vacc_or = vacc | shifted[31:0];

  // Per-byte parse step.
  always_comb begin
    phase_next      = phase;
    hdr_idx_next    = hdr_idx;
    base_seq_next   = base_seq;
    decl_count_next = decl_count;
    rec_count_next  = rec_count;
    vacc_next       = vacc;
    vbytes_next     = vbytes;
    remain_next     = remain;
    cur_op_next     = cur_op;
    err_code_next   = err_code;
    cur_seq_next    = cur_seq;
    fin             = 1'b0;
    in_rec          = 1'b0;
    beat            = '0;
    beat.data_out   = b;
    beat.byte_role  = wbrp_pkg::PH_DISCARD;
    beat.done_res   = q_data.last_byte;

    unique case (phase)
      wbrp_pkg::PH_HEADER: begin
        beat.byte_role = wbrp_pkg::PH_HEADER;
        if (hdr_idx < 4'(wbrp_pkg::SEQ_BYTES)) begin
          base_seq_next[{hdr_idx[2:0], 3'b000} +: 8] = b;
        end else if (hdr_idx < 4'(wbrp_pkg::HEADER_BYTES)) begin
          decl_count_next[{hdr_idx[1:0], 3'b000} +: 8] = b;
        end
        hdr_idx_next = hdr_idx + 4'd1;
        if (hdr_idx_next >= 4'(wbrp_pkg::HEADER_BYTES)) begin
          phase_next = wbrp_pkg::PH_TAG;
        end
      end
      wbrp_pkg::PH_TAG: begin
        beat.byte_role  = wbrp_pkg::PH_TAG;
        rec_count_next  = rec_count + 32'd1;
        cur_seq_next    = base_seq + {32'd0, rec_count};
        beat.record_seq = cur_seq_next;
        vacc_next       = '0;
        vbytes_next     = '0;
        if (q_data.is_put) begin
          cur_op_next = wbrp_pkg::OP_PUT;
          phase_next  = wbrp_pkg::PH_KLEN;
          in_rec      = 1'b1;
        end else if (q_data.is_del) begin
          cur_op_next = wbrp_pkg::OP_DELETE;
          phase_next  = wbrp_pkg::PH_KLEN;
          in_rec      = 1'b1;
        end else begin
          cur_op_next   = wbrp_pkg::OP_PUT;
          err_code_next = wbrp_pkg::ST_BADTAG;
          phase_next    = wbrp_pkg::PH_DISCARD;
        end
      end
      wbrp_pkg::PH_KLEN, wbrp_pkg::PH_VLEN: begin
        beat.byte_role  = phase;
        beat.record_seq = cur_seq;
        in_rec          = 1'b1;
        vacc_next       = vacc_or;
        if (b[7]) begin
          if (vbytes >= 3'd4) begin
            err_code_next = cur_op ? wbrp_pkg::ST_BADDEL : wbrp_pkg::ST_BADPUT;
            phase_next    = wbrp_pkg::PH_DISCARD;
          end else begin
            vbytes_next = vbytes + 3'd1;
          end
        end else begin
          remain_next = vacc_or;
          if (vacc_or == 32'd0) begin
            fin = 1'b1;
          end else begin
            phase_next = is_key ? wbrp_pkg::PH_KEY : wbrp_pkg::PH_VAL;
          end
        end
      end
      wbrp_pkg::PH_KEY, wbrp_pkg::PH_VAL: begin
        beat.byte_role  = phase;
        beat.record_seq = cur_seq;
        in_rec          = 1'b1;
        remain_next     = remain - 32'd1;
        if (remain_next == 32'd0) begin
          fin = 1'b1;
        end
      end
      default: begin
        beat.byte_role = wbrp_pkg::PH_DISCARD;
      end
    endcase

    // A key or value has completed; a put key goes on to its value.
    if (fin) begin
      beat.field_end = 1'b1;
      vacc_next      = '0;
      vbytes_next    = '0;
      if (is_key && (cur_op == wbrp_pkg::OP_PUT)) begin
        phase_next = wbrp_pkg::PH_VLEN;
      end else begin
        beat.record_end = 1'b1;
        phase_next      = wbrp_pkg::PH_TAG;
      end
    end

    if (in_rec) begin
      beat.record_op = cur_op_next;
    end

    // Batch status on the last byte, then back to the start of a batch.
    if (q_data.last_byte) begin
      if (err_code_next != wbrp_pkg::ST_OK) begin
        beat.status = err_code_next;
      end else if (phase_next == wbrp_pkg::PH_HEADER) begin
        beat.status = wbrp_pkg::ST_SMALL;
      end else if (phase_next == wbrp_pkg::PH_TAG) begin
        beat.status = (rec_count_next == decl_count_next) ? wbrp_pkg::ST_OK
                                                          : wbrp_pkg::ST_COUNT;
      end else begin
        beat.status = cur_op_next ? wbrp_pkg::ST_BADDEL : wbrp_pkg::ST_BADPUT;
      end
      phase_next     = wbrp_pkg::PH_HEADER;
      hdr_idx_next   = '0;
      rec_count_next = '0;
      vacc_next      = '0;
      vbytes_next    = '0;
      remain_next    = '0;
      cur_op_next    = wbrp_pkg::OP_PUT;
      err_code_next  = wbrp_pkg::ST_OK;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= wbrp_pkg::PH_HEADER;
      hdr_idx   <= '0;
      rec_count <= '0;
      vacc      <= '0;
      vbytes    <= '0;
      remain    <= '0;
      cur_op    <= wbrp_pkg::OP_PUT;
      err_code  <= wbrp_pkg::ST_OK;
    end else if (take) begin
      phase     <= phase_next;
      hdr_idx   <= hdr_idx_next;
      rec_count <= rec_count_next;
      vacc      <= vacc_next;
      vbytes    <= vbytes_next;
      remain    <= remain_next;
      cur_op    <= cur_op_next;
      err_code  <= err_code_next;
    end
  end

  // Header values and the record sequence are rewritten before they are used.
  always_ff @(posedge clk) begin
    if (take) begin
      base_seq   <= base_seq_next;
      decl_count <= decl_count_next;
      cur_seq    <= cur_seq_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= beat;
    end
  end

endmodule
